// File: hw/rtl/ppse_pkg.sv
// Shared types, codes and arithmetic helpers of the spline evaluator.
package ppse_pkg;

  localparam int DATA_W           = 32;
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_POLY_DEGREE  = 5;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EVAL = 1'b1;
  localparam logic [2:0] SEL_START = 3'd0;
  localparam logic [2:0] SEL_END   = 3'd1;
  localparam logic [2:0] SEL_COEF0 = 3'd2;

  typedef struct packed {
    logic              func;
    logic [3:0]        seg_index;
    logic [2:0]        word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] query_time;
    logic [1:0]        derivative;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic              saturated;
    logic [3:0]        segment_used;
  } result_t;

  // Per-stage control that travels alongside the data.
  typedef struct packed {
    logic              valid;
    logic              func;
    logic              wr_ok;
    logic              zero;
    logic [3:0]        seg_index;
    logic [2:0]        word_select;
    logic signed [31:0] word_value;
    logic [1:0]        derivative;
  } ctl_t;

  // Clip to the 32-bit range; bit 32 of the result flags a clip.
  function automatic logic [32:0] sat_word(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Derivative weight k*(k-1)*...*(k-d+1).
  function automatic logic [7:0] weight(input int k, input logic [1:0] d);
    int w;
    w = 1;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(d)) w = w * (k - j);
    end
    return 8'(w);
  endfunction

endpackage

// File: hw/rtl/piecewise_polynomial_spline_eval.sv
// Top level of the pipelined piecewise polynomial spline evaluator.
// Usage: configure cfg_data (segment count) with cfg_we while the block is idle.
// Items arrive on item_valid/item_ready. A load transaction (func 0) writes one
// word of one segment and yields no result; an evaluate transaction (func 1)
// yields one result on result_valid/result_ready.
// Throughput: one transaction per cycle while the output is not stalled. Every transaction, load or evaluate,
// walks the same pipeline, so loads and evaluates keep their order.
// Pipeline stages from accept to result_valid: one clamp stage, one stage per
// search step, a start fetch stage, an offset stage, two stages per Horner step
// (coefficient fetch, then multiply, with shift-add-clip behind it) and the
// output register.
// Each stage holds its own copy of the tables it reads, written by loads as
// they pass, so every stage reads at one address per cycle.
// Reset (rst, synchronous) clears the segment count and all valid bits; the
// segment tables keep their contents and read as undefined until loaded.
// Stall: while result_valid is high and result_ready low the whole pipeline
// holds and item_ready drops; nothing is lost or repeated.
module piecewise_polynomial_spline_eval
  import ppse_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int POLY_DEGREE  = DEF_POLY_DEGREE,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SS = AW;
  localparam int NC = POLY_DEGREE + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SEGMENTS - 1);

  logic [4:0]    segment_count;
  logic          adv;
  logic          acc_in;
  ctl_t          ctl0;
  logic [AW-1:0] nm1;
  logic          ld0;

  // Segment count register; the user must write it only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
    end else if (cfg_we) begin
      segment_count <= cfg_data;
    end
  end

  // Whole pipeline advances unless the output register is stalled.
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign acc_in     = item_valid && item_ready;

  assign nm1 = (32'(segment_count) >= 32'(MAX_SEGMENTS)) ? LAST_IDX
             : AW'(segment_count - 5'd1);

  always_comb begin
    ctl0             = '0;
    ctl0.valid       = acc_in;
    ctl0.func        = item.func;
    ctl0.wr_ok       = (32'(item.seg_index) < 32'(MAX_SEGMENTS));
    ctl0.zero        = (segment_count == 5'd0);
    ctl0.seg_index   = item.seg_index;
    ctl0.word_select = item.word_select;
    ctl0.word_value  = item.word_value;
    ctl0.derivative  = item.derivative;
  end

  assign ld0 = ctl0.valid && (ctl0.func == FUNC_LOAD) && ctl0.wr_ok;

  // ---- Clamp stage: first start and last end of the table ----
  ctl_t               s1_ctl;
  logic signed [31:0] s1_qt;
  logic signed [31:0] first_start;
  logic signed [31:0] last_end;
  logic signed [31:0] t_lo;
  logic signed [31:0] t_clamp;

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_first_start (
    .clk(clk), .we(adv && ld0 && (ctl0.word_select == SEL_START)),
    .waddr(AW'(ctl0.seg_index)), .wdata(ctl0.word_value),
    .re(adv), .raddr('0), .rdata(first_start)
  );

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_last_end (
    .clk(clk), .we(adv && ld0 && (ctl0.word_select == SEL_END)),
    .waddr(AW'(ctl0.seg_index)), .wdata(ctl0.word_value),
    .re(adv), .raddr(nm1), .rdata(last_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= ctl0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s1_qt <= item.query_time;
  end

  // Clamp low first, then high, as the search expects.
  assign t_lo    = (s1_qt <= first_start) ? first_start : s1_qt;
  assign t_clamp = (t_lo >= last_end) ? last_end : t_lo;

  // ---- Binary search, one step per stage ----
  ctl_t               sr_ctl [SS];
  logic signed [31:0] sr_t   [SS];
  logic [AW-1:0]      sr_lo  [SS];
  logic [AW-1:0]      sr_hi  [SS];

  for (genvar j = 0; j < SS; j++) begin : g_search
    if (j == 0) begin : g_first
      ppse_search_step #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_step (
        .clk(clk), .rst(rst), .adv(adv),
        .ctl_in(s1_ctl), .t_in(t_clamp), .lo_in('0), .hi_in(nm1),
        .ctl_out(sr_ctl[j]), .t_out(sr_t[j]), .lo_out(sr_lo[j]), .hi_out(sr_hi[j])
      );
    end else begin : g_next
      ppse_search_step #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_step (
        .clk(clk), .rst(rst), .adv(adv),
        .ctl_in(sr_ctl[j-1]), .t_in(sr_t[j-1]), .lo_in(sr_lo[j-1]),
        .hi_in(sr_hi[j-1]),
        .ctl_out(sr_ctl[j]), .t_out(sr_t[j]), .lo_out(sr_lo[j]), .hi_out(sr_hi[j])
      );
    end
  end

  // ---- Fetch stage: start of the chosen segment ----
  ctl_t               f_ctl;
  logic signed [31:0] f_t;
  logic [AW-1:0]      f_hi;
  logic signed [31:0] f_start;
  logic               ld_f;

  assign ld_f = adv && sr_ctl[SS-1].valid && (sr_ctl[SS-1].func == FUNC_LOAD)
                && sr_ctl[SS-1].wr_ok && (sr_ctl[SS-1].word_select == SEL_START);

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_seg_start (
    .clk(clk), .we(ld_f), .waddr(AW'(sr_ctl[SS-1].seg_index)),
    .wdata(sr_ctl[SS-1].word_value),
    .re(adv), .raddr(sr_hi[SS-1]), .rdata(f_start)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else if (adv) begin
      f_ctl <= sr_ctl[SS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_t  <= sr_t[SS-1];
      f_hi <= sr_hi[SS-1];
    end
  end

  // ---- Offset stage: dt = t - start, clipped ----
  ctl_t               d_ctl;
  logic [AW-1:0]      d_hi;
  logic signed [31:0] d_dt;
  logic               d_sat;
  logic [32:0]        dt_clip;

  assign dt_clip = sat_word(66'(f_t) - 66'(f_start));

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else if (adv) begin
      d_ctl <= f_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_hi  <= f_hi;
      d_dt  <= $signed(dt_clip[31:0]);
      d_sat <= dt_clip[32];
    end
  end

  // ---- Horner steps, highest coefficient first ----
  ctl_t               h_ctl [NC];
  logic [AW-1:0]      h_hi  [NC];
  logic signed [31:0] h_dt  [NC];
  logic signed [31:0] h_acc [NC];
  logic               h_sat [NC];

  for (genvar i = 0; i < NC; i++) begin : g_horner
    if (i == 0) begin : g_first
      ppse_horner_step #(
        .MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS), .K(POLY_DEGREE)
      ) u_step (
        .clk(clk), .rst(rst), .adv(adv),
        .ctl_in(d_ctl), .hi_in(d_hi), .dt_in(d_dt), .acc_in('0), .sat_in(d_sat),
        .ctl_out(h_ctl[i]), .hi_out(h_hi[i]), .dt_out(h_dt[i]),
        .acc_out(h_acc[i]), .sat_out(h_sat[i])
      );
    end else begin : g_next
      ppse_horner_step #(
        .MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS), .K(POLY_DEGREE - i)
      ) u_step (
        .clk(clk), .rst(rst), .adv(adv),
        .ctl_in(h_ctl[i-1]), .hi_in(h_hi[i-1]), .dt_in(h_dt[i-1]),
        .acc_in(h_acc[i-1]), .sat_in(h_sat[i-1]),
        .ctl_out(h_ctl[i]), .hi_out(h_hi[i]), .dt_out(h_dt[i]),
        .acc_out(h_acc[i]), .sat_out(h_sat[i])
      );
    end
  end

  // ---- Output register: evaluate transactions only ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= h_ctl[NC-1].valid && (h_ctl[NC-1].func == FUNC_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (h_ctl[NC-1].zero) begin
        result <= '0;
      end else begin
        result.value        <= h_acc[NC-1];
        result.saturated    <= h_sat[NC-1];
        result.segment_used <= 4'(h_hi[NC-1]);
      end
    end
  end

endmodule

// File: hw/rtl/ppse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ppse_search_step.sv
// One binary-search step: fetch bounds of the middle segment, then narrow.
module ppse_search_step
  import ppse_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  ctl_t               ctl_in,
  input  logic signed [31:0] t_in,
  input  logic [AW-1:0]      lo_in,
  input  logic [AW-1:0]      hi_in,
  output ctl_t               ctl_out,
  output logic signed [31:0] t_out,
  output logic [AW-1:0]      lo_out,
  output logic [AW-1:0]      hi_out
);

  ctl_t               ctl;
  logic signed [31:0] t;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [AW-1:0]      mid_in;
  logic [AW-1:0]      mid;
  logic signed [31:0] seg_st;
  logic signed [31:0] seg_en;
  logic               ld;

  assign mid_in = AW'(({1'b0, lo_in} + {1'b0, hi_in}) >> 1);
  assign ld = adv && ctl_in.valid && (ctl_in.func == FUNC_LOAD) && ctl_in.wr_ok;

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_start (
    .clk(clk), .we(ld && (ctl_in.word_select == SEL_START)),
    .waddr(AW'(ctl_in.seg_index)), .wdata(ctl_in.word_value),
    .re(adv), .raddr(mid_in), .rdata(seg_st)
  );

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_end (
    .clk(clk), .we(ld && (ctl_in.word_select == SEL_END)),
    .waddr(AW'(ctl_in.seg_index)), .wdata(ctl_in.word_value),
    .re(adv), .raddr(mid_in), .rdata(seg_en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t  <= t_in;
      lo <= lo_in;
      hi <= hi_in;
    end
  end

  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // Narrow the interval; a settled interval holds.
  always_comb begin
    lo_out = lo;
    hi_out = hi;
    if (lo != hi) begin
      if (t < seg_st) begin
        hi_out = (mid > lo) ? mid - AW'(1) : lo;
      end else if (t > seg_en) begin
        lo_out = mid + AW'(1);
      end else begin
        lo_out = mid;
        hi_out = mid;
      end
    end
  end

  assign ctl_out = ctl;
  assign t_out   = t;

endmodule

// File: hw/rtl/ppse_horner_step.sv
// One weighted Horner step: fetch c_k, multiply, then shift, add and clip.
module ppse_horner_step
  import ppse_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int K            = 0,
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  ctl_t               ctl_in,
  input  logic [AW-1:0]      hi_in,
  input  logic signed [31:0] dt_in,
  input  logic signed [31:0] acc_in,
  input  logic               sat_in,
  output ctl_t               ctl_out,
  output logic [AW-1:0]      hi_out,
  output logic signed [31:0] dt_out,
  output logic signed [31:0] acc_out,
  output logic               sat_out
);

  ctl_t               ctl1;
  logic [AW-1:0]      hi1;
  logic signed [31:0] dt1;
  logic signed [31:0] acc1;
  logic               sat1;
  logic signed [31:0] coef;

  ctl_t               ctl2;
  logic [AW-1:0]      hi2;
  logic signed [31:0] dt2;
  logic signed [31:0] acc2;
  logic               sat2;
  logic               act2;
  logic signed [63:0] prod2;
  logic signed [40:0] cw2;

  logic signed [63:0] prod_sh;
  logic signed [65:0] sum;
  logic [32:0]        clip;
  logic               ld;

  assign ld = adv && ctl_in.valid && (ctl_in.func == FUNC_LOAD) && ctl_in.wr_ok
              && ({1'b0, ctl_in.word_select} == 4'(int'(SEL_COEF0) + K));

  ppse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_coef (
    .clk(clk), .we(ld), .waddr(AW'(ctl_in.seg_index)), .wdata(ctl_in.word_value),
    .re(adv), .raddr(hi_in), .rdata(coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else if (adv) begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi1   <= hi_in;
      dt1   <= dt_in;
      acc1  <= acc_in;
      sat1  <= sat_in;
      hi2   <= hi1;
      dt2   <= dt1;
      acc2  <= acc1;
      sat2  <= sat1;
      act2  <= (int'(ctl1.derivative) <= K);
      prod2 <= acc1 * dt1;
      cw2   <= coef * $signed({1'b0, weight(K, ctl1.derivative)});
    end
  end

  // Floor shift, add the weighted coefficient, clip.
  assign prod_sh = prod2 >>> FRAC_BITS;
  assign sum     = {{2{prod_sh[63]}}, prod_sh} + {{25{cw2[40]}}, cw2};
  assign clip    = sat_word(sum);

  assign ctl_out = ctl2;
  assign hi_out  = hi2;
  assign dt_out  = dt2;
  assign acc_out = act2 ? $signed(clip[31:0]) : acc2;
  assign sat_out = sat2 | (act2 & clip[32]);

endmodule

// File: hw/rtl/ppse_checker.sv
// Port-level checks of the spline evaluator, bound to the top level.
module ppse_checker
  import ppse_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // No result right after reset.
  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A waiting input transaction holds.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("waiting input transaction changed");

  // Input stalls exactly when the output is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_ready == (!result_valid || result_ready))
    else $error("item_ready does not follow output stall");

endmodule

bind piecewise_polynomial_spline_eval ppse_checker u_chk (.*);
